/* sv/lss_pkg.sv */
// Shared constants, register codes and byte classification helpers for the line search block.
package lss_pkg;

  localparam logic [7:0] BYTE_CR         = 8'h0d;
  localparam logic [7:0] BYTE_LF         = 8'h0a;
  localparam logic [7:0] BYTE_UNDERSCORE = 8'h5f;
  localparam logic [7:0] BYTE_HIGH_START = 8'h80;
  localparam logic [5:0] COUNT_MAX       = 6'd63;
  localparam int         PATTERN_BYTES   = 32;

  typedef enum logic [2:0] {
    REG_PATTERN_WORD0   = 3'd0,
    REG_PATTERN_WORD1   = 3'd1,
    REG_PATTERN_WORD2   = 3'd2,
    REG_PATTERN_WORD3   = 3'd3,
    REG_PATTERN_LENGTH  = 3'd4,
    REG_CASE_SENSITIVE  = 3'd5,
    REG_WHOLE_WORD_ONLY = 3'd6
  } cfg_reg_t;

  // letters, digits and underscore; anything at or above 0x80 is a boundary
  function automatic logic is_word_byte(input logic [7:0] b);
    logic res;
    res = 1'b0;
    if (b < BYTE_HIGH_START) begin
      if (b >= 8'h30 && b <= 8'h39) res = 1'b1;
      if (b >= 8'h41 && b <= 8'h5a) res = 1'b1;
      if (b >= 8'h61 && b <= 8'h7a) res = 1'b1;
      if (b == BYTE_UNDERSCORE) res = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
    logic [7:0] res;
    res = b;
    if (!exact && b >= 8'h61 && b <= 8'h7a) res = b - 8'h20;
    return res;
  endfunction

endpackage

/* sv/line_substring_search_top.sv */
// Line substring search: per-byte window compare against a configured pattern, one result per line.
// Pipeline: a byte accepted into the input register is compared from there, and its line result
//   (if any) is written into the output register; a full output register can hold the compare.
// Throughput: one text byte per cycle, set by the combinational window compare; stalls only
//   while a result waits in the output register and the sink holds m_axis_tready low.
// Reset (rst, synchronous) clears line state, sets the line number to one and the match count
//   to zero; pattern changes reach the aligned compare register through the configuration registers.
module line_substring_search_top #(
  parameter int PATTERN_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] line_number, [63:32] matching_lines
  output logic        m_axis_tuser,   // [0] line_matched
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import lss_pkg::*;

  // configuration registers
  logic [63:0] pattern_word [4];
  logic [5:0]  pattern_length;
  logic        case_sensitive;
  logic        whole_word_only;

  // pattern realigned to the window: rpat[k] is compared with window byte k
  logic [7:0]  rpat [PATTERN_MAX];
  logic        in_use [PATTERN_MAX];
  logic        before_sel [PATTERN_MAX+1];
  logic [5:0]  used_len;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_eos;

  // line state
  logic [7:0]  window [PATTERN_MAX+1];
  logic [5:0]  line_byte_count;
  logic        tail_check_pending;
  logic        line_hit;
  logic        after_cr;
  logic [31:0] line_counter;
  logic [31:0] match_count;

  logic        advance;
  logic        process;

  cfg_reg_t    cfg_sel;
  logic        cfg_write;

  logic [5:0]   used_len_c;
  logic [255:0] rev_pat;
  logic [255:0] aligned_pat;
  logic [4:0]   align_shift;

  logic [7:0]  win_n [PATTERN_MAX+1];
  logic [5:0]  count_inc;
  logic        all_eq;
  logic        before_word;
  logic        take_hit;
  logic        take_pend;
  logic        fin_hit;
  logic        emit;
  logic        clear;
  logic        shift;
  logic [5:0]  line_byte_count_next;
  logic        tail_check_pending_next;
  logic        line_hit_next;
  logic        after_cr_next;
  logic [31:0] line_counter_next;
  logic [31:0] match_count_next;

  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[5:3]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) pattern_word[w] <= '0;
      pattern_length  <= 6'd1;
      case_sensitive  <= 1'b0;
      whole_word_only <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_PATTERN_WORD0:   pattern_word[0] <= pwdata;
        REG_PATTERN_WORD1:   pattern_word[1] <= pwdata;
        REG_PATTERN_WORD2:   pattern_word[2] <= pwdata;
        REG_PATTERN_WORD3:   pattern_word[3] <= pwdata;
        REG_PATTERN_LENGTH:  pattern_length  <= pwdata[5:0];
        REG_CASE_SENSITIVE:  case_sensitive  <= pwdata[0];
        REG_WHOLE_WORD_ONLY: whole_word_only <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PATTERN_WORD0:   prdata = pattern_word[0];
      REG_PATTERN_WORD1:   prdata = pattern_word[1];
      REG_PATTERN_WORD2:   prdata = pattern_word[2];
      REG_PATTERN_WORD3:   prdata = pattern_word[3];
      REG_PATTERN_LENGTH:  prdata = {58'd0, pattern_length};
      REG_CASE_SENSITIVE:  prdata = {63'd0, case_sensitive};
      REG_WHOLE_WORD_ONLY: prdata = {63'd0, whole_word_only};
      default:             prdata = '0;
    endcase
  end

  // zero length acts as one, anything beyond the window acts as the maximum
  always_comb begin
    priority if (pattern_length == 6'd0)                used_len_c = 6'd1;
    else if (pattern_length > 6'(PATTERN_MAX))          used_len_c = 6'(PATTERN_MAX);
    else                                                used_len_c = pattern_length;
  end

  // byte-reverse the pattern, then shift right so pattern byte len-1 lands in byte 0
  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      rev_pat[j*8 +: 8] = pattern_word[(PATTERN_BYTES-1-j) / 8][((PATTERN_BYTES-1-j) % 8)*8 +: 8];
    end
    align_shift = 5'(6'(PATTERN_BYTES) - used_len_c);
    aligned_pat = rev_pat >> {align_shift, 3'b000};
  end

  always_ff @(posedge clk) begin
    used_len <= used_len_c;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      rpat[k]   <= fold_byte(aligned_pat[k*8 +: 8], case_sensitive);
      in_use[k] <= (6'(k) < used_len_c);
    end
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      before_sel[k] <= (6'(k) == used_len_c);
    end
  end

  // handshake: the output register parts the sides
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign process       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  // text byte path: shift, compare, word edge checks
  always_comb begin
    win_n[0] = in_byte;
    for (int k = 1; k <= PATTERN_MAX; k++) win_n[k] = window[k-1];
    count_inc = (line_byte_count == COUNT_MAX) ? line_byte_count : line_byte_count + 6'd1;

    all_eq = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (in_use[k] && fold_byte(win_n[k], case_sensitive) != rpat[k]) all_eq = 1'b0;
    end
    before_word = 1'b0;
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      if (before_sel[k] && is_word_byte(win_n[k])) before_word = 1'b1;
    end

    take_hit  = line_hit | (tail_check_pending & !is_word_byte(in_byte));
    take_pend = 1'b0;
    if (count_inc >= used_len && all_eq) begin
      if (!whole_word_only) begin
        take_hit = 1'b1;
      end else if (count_inc == used_len || !before_word) begin
        take_pend = 1'b1;
      end
    end
  end

  // line framing: CR, LF, CR LF and end of stream
  always_comb begin
    emit                    = 1'b0;
    clear                   = 1'b0;
    shift                   = 1'b0;
    fin_hit                 = 1'b0;
    line_byte_count_next    = line_byte_count;
    tail_check_pending_next = tail_check_pending;
    line_hit_next           = line_hit;
    after_cr_next           = after_cr;
    line_counter_next       = line_counter;
    match_count_next        = match_count;

    priority if (after_cr && in_byte == BYTE_LF) begin
      after_cr_next = 1'b0;
    end else if (in_byte == BYTE_CR || in_byte == BYTE_LF) begin
      emit          = 1'b1;
      clear         = 1'b1;
      fin_hit       = line_hit | tail_check_pending;
      after_cr_next = (in_byte == BYTE_CR);
    end else begin
      after_cr_next           = 1'b0;
      shift                   = 1'b1;
      line_byte_count_next    = count_inc;
      line_hit_next           = take_hit;
      tail_check_pending_next = take_pend;
      if (in_eos) begin
        emit    = 1'b1;
        clear   = 1'b1;
        fin_hit = take_hit | take_pend;
      end
    end

    if (emit) begin
      if (fin_hit && match_count != '1) match_count_next = match_count + 32'd1;
      if (line_counter != '1) line_counter_next = line_counter + 32'd1;
    end
    if (clear || in_eos) begin
      line_byte_count_next    = '0;
      line_hit_next           = 1'b0;
      tail_check_pending_next = 1'b0;
    end
    if (in_eos) begin
      line_counter_next = 32'd1;
      after_cr_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_byte_count    <= '0;
      tail_check_pending <= 1'b0;
      line_hit           <= 1'b0;
      after_cr           <= 1'b0;
      line_counter       <= 32'd1;
      match_count        <= '0;
    end else if (process) begin
      line_byte_count    <= line_byte_count_next;
      tail_check_pending <= tail_check_pending_next;
      line_hit           <= line_hit_next;
      after_cr           <= after_cr_next;
      line_counter       <= line_counter_next;
      match_count        <= match_count_next;
    end
    // window is only read below the fill count, so it needs no clearing
    if (process && shift) begin
      for (int k = 0; k <= PATTERN_MAX; k++) window[k] <= win_n[k];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (process && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (process && emit) begin
      m_axis_tdata <= {match_count_next, line_counter};
      m_axis_tuser <= fin_hit;
    end
  end

  a_line_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_counter != 32'd0)
    else $error("line counter reached zero");

  a_empty_line_clean: assert property (@(posedge clk) disable iff (rst)
    line_byte_count == 6'd0 |-> (!line_hit && !tail_check_pending))
    else $error("hit state left over in an empty line");

  a_match_count_step: assert property (@(posedge clk) disable iff (rst)
    (process && emit && fin_hit && match_count != '1) |=>
      match_count == $past(match_count) + 32'd1)
    else $error("matching line not counted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");

endmodule
